@@ hdl/sfe_pkg.sv @@
// Shared types and constants for the 3x3 Sobel edge filter.
package sfe_pkg;

    typedef logic [7:0] t_pix;

    // One window column, top row first
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    // Per-cell control from the position sequencer
    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctl;

    // Line store word: row two above and row one above
    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_ls_word;

    // Result beat payload
    typedef struct packed {
        logic last;
        t_pix vert;
        t_pix horiz;
    } t_result;

    localparam int   CFG_W        = 10;
    localparam int   CFG_RST      = 512;
    localparam int   MIN_DIM      = 3;
    localparam logic ACT_PIXEL    = 1'b0;
    localparam logic ACT_DRAIN    = 1'b1;
    localparam logic REG_WIDTH    = 1'b0;
    localparam logic REG_HEIGHT   = 1'b1;

endpackage

@@ hdl/sfe_col_cell.sv @@
// One window column cell: holds three pixels, loads from its right neighbor.
module sfe_col_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfe_pkg::t_cell_ctl i_ctl,
    input  sfe_pkg::t_col     i_col,
    output sfe_pkg::t_col     o_col
);
    import sfe_pkg::*;

    t_col r_col;
    t_col n_col;

    // Clear wins over load
    always_comb begin
        n_col = r_col;
        if (i_ctl.clear) begin
            n_col = '0;
        end else if (i_ctl.load) begin
            n_col = i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

@@ hdl/sfe_kernel.sv @@
// Sobel horizontal and vertical kernels over a 3x3 window, clamped to 0..255.
module sfe_kernel (
    input  sfe_pkg::t_col i_left,
    input  sfe_pkg::t_col i_centre,
    input  sfe_pkg::t_col i_right,
    output sfe_pkg::t_pix o_horiz,
    output sfe_pkg::t_pix o_vert
);
    import sfe_pkg::*;

    logic [9:0]         s_upper;
    logic [9:0]         s_lower;
    logic [9:0]         s_leftc;
    logic [9:0]         s_rightc;
    logic signed [10:0] d_horiz;
    logic signed [10:0] d_vert;

    function automatic t_pix clamp_pix(input logic signed [10:0] s);
        t_pix res;
        if (s < 0) begin
            res = '0;
        end else if (s > 11'sd255) begin
            res = 8'hFF;
        end else begin
            res = s[7:0];
        end
        return res;
    endfunction

    // 1-2-1 weighted sums of the outer rows and columns
    always_comb begin
        s_upper  = {2'b0, i_left.top} + {1'b0, i_centre.top, 1'b0} + {2'b0, i_right.top};
        s_lower  = {2'b0, i_left.bot} + {1'b0, i_centre.bot, 1'b0} + {2'b0, i_right.bot};
        s_leftc  = {2'b0, i_left.top} + {1'b0, i_left.mid, 1'b0} + {2'b0, i_left.bot};
        s_rightc = {2'b0, i_right.top} + {1'b0, i_right.mid, 1'b0} + {2'b0, i_right.bot};
        d_horiz  = $signed({1'b0, s_upper}) - $signed({1'b0, s_lower});
        d_vert   = $signed({1'b0, s_leftc}) - $signed({1'b0, s_rightc});
    end

    assign o_horiz = clamp_pix(d_horiz);
    assign o_vert  = clamp_pix(d_vert);

endmodule

@@ hdl/sfe_line_store.sv @@
// Dual line store: one write port and one registered read port.
module sfe_line_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  sfe_pkg::t_ls_word i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output sfe_pkg::t_ls_word o_rdata
);
    import sfe_pkg::*;

    t_ls_word mem [DEPTH];
    t_ls_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sobel_edge_filter_3x3_core.sv @@
// Top level of the streaming 3x3 Sobel edge filter with zero padding.
//
// Input stream: one beat per pixel in raster order; tdata carries the pixel,
// tuser the action (pixel or drain). Output stream: one beat per frame pixel
// with horizontal and vertical responses in tdata and tlast on the frame's
// final pixel. A result trails its pixel by one row plus one position, so
// W+1 drain beats after the last pixel flush the frame.
// Throughput: one beat per cycle while tready is high; the line store reads
// the next column's word ahead of use and the window is a two-cell column chain.
// A result is registered into the output buffer when the input beat that
// completes its window is accepted.
// A two-entry output buffer decouples the sides: input beats keep flowing
// while one result waits; tready drops only once both entries hold data.
// Reset clears position, window and output buffer, and sets both frame
// registers to 512; the size in use is capped at the maxima. Line store
// contents are not cleared; rows above the frame are masked to zero.
// The APB port writes frame_width at 0x0 and frame_height at 0x4; a write
// restarts the frame.
module sobel_edge_filter_3x3_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] pixel
    input  logic        i_s_tuser,   // [0] action
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] horizontal_edge, [15:8] vertical_edge
    output logic        o_m_tlast,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfe_pkg::*;

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int CW0   = (WW > CFG_W) ? WW : CFG_W;
    localparam int CW    = ((RW > CW0) ? RW : CW0) + 1;
    localparam int W_RST = (MAX_WIDTH < CFG_RST) ? MAX_WIDTH : CFG_RST;
    localparam int H_RST = (MAX_HEIGHT < CFG_RST) ? MAX_HEIGHT : CFG_RST;

    // Configuration registers
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [AW-1:0]    r_w_m1;
    logic [RW-1:0]    r_h;
    logic [RW-1:0]    r_hp1;

    // Position
    logic [AW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [AW-1:0]    n_col;
    logic [RW-1:0]    n_row;

    // Output buffer
    t_result          r_out;
    t_result          r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;

    logic             cfg_wr;
    logic [CW-1:0]    cfg_ext;
    logic [CW-1:0]    w_sat;
    logic [CW-1:0]    h_sat;
    logic             acc;
    logic             pop;
    logic             col0;
    logic             has_res;
    logic             is_last;
    logic             push;
    t_pix             cur;
    t_pix             top;
    t_pix             mid;
    t_col             right_col;
    t_col             kern_right;
    t_col             left_q;
    t_col             centre_q;
    t_cell_ctl        ctl_left;
    t_cell_ctl        ctl_centre;
    t_ls_word         ls_rd;
    t_ls_word         ls_wr;
    logic [AW-1:0]    ls_raddr;
    t_pix             kern_horiz;
    t_pix             kern_vert;
    t_result          res;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-CFG_W){1'b0}}, r_cfg_height}
                                             : {{(32-CFG_W){1'b0}}, r_cfg_width};

    // Saturate written dimension to 3..MAX
    always_comb begin
        cfg_ext = CW'(pwdata[CFG_W-1:0]);
        if (cfg_ext < CW'(MIN_DIM)) begin
            w_sat = CW'(MIN_DIM);
            h_sat = CW'(MIN_DIM);
        end else begin
            w_sat = (cfg_ext > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : cfg_ext;
            h_sat = (cfg_ext > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : cfg_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(CFG_RST);
            r_cfg_height <= CFG_W'(CFG_RST);
            r_w_m1       <= AW'(W_RST - 1);
            r_h          <= RW'(H_RST);
            r_hp1        <= RW'(H_RST + 1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_cfg_width <= pwdata[CFG_W-1:0];
                r_w_m1      <= AW'(w_sat - CW'(1));
            end else begin
                r_cfg_height <= pwdata[CFG_W-1:0];
                r_h          <= RW'(h_sat);
                r_hp1        <= RW'(h_sat + CW'(1));
            end
        end
    end

    // Beat handshakes
    assign o_s_tready = !r_skid_valid;
    assign acc        = i_s_tvalid && o_s_tready;
    assign pop        = r_out_valid && i_m_tready;

    // Window inputs for the current position
    assign col0    = (r_col == '0);
    assign has_res = col0 ? (r_row >= RW'(2)) : (r_row != '0);
    assign is_last = col0 && (r_row == r_hp1);
    assign cur     = ((r_row < r_h) && (i_s_tuser == ACT_PIXEL)) ? i_s_tdata : '0;
    assign top     = (r_row >= RW'(2)) ? ls_rd.older : '0;
    assign mid     = (r_row != '0) ? ls_rd.newer : '0;

    always_comb begin
        right_col.top = top;
        right_col.mid = mid;
        right_col.bot = cur;
        kern_right    = col0 ? '0 : right_col;
    end

    // Position sequencer
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (acc) begin
            if (is_last) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col == r_w_m1) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line stores, prefetching the word of the next position
    assign ls_raddr    = i_rst_n ? n_col : '0;
    assign ls_wr.older = ls_rd.newer;
    assign ls_wr.newer = cur;

    sfe_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (r_col),
        .i_wdata (ls_wr),
        .i_raddr (ls_raddr),
        .o_rdata (ls_rd)
    );

    // Column cell chain: right column -> centre -> left
    always_comb begin
        ctl_centre.load  = acc;
        ctl_centre.clear = cfg_wr || (acc && is_last);
        ctl_left.load    = acc;
        ctl_left.clear   = cfg_wr || (acc && col0);
    end

    sfe_col_cell u_cell_centre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_centre),
        .i_col   (right_col),
        .o_col   (centre_q)
    );

    sfe_col_cell u_cell_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_left),
        .i_col   (centre_q),
        .o_col   (left_q)
    );

    sfe_kernel u_kernel (
        .i_left   (left_q),
        .i_centre (centre_q),
        .i_right  (kern_right),
        .o_horiz  (kern_horiz),
        .o_vert   (kern_vert)
    );
    assign res  = {is_last, kern_vert, kern_horiz};
    assign push = acc && has_res;

    // Two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.vert, r_out.horiz};
    assign o_m_tlast  = r_out.last;

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a head entry");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_last) |=> (r_col == '0) && (r_row == '0))
        else $error("frame did not restart after its final result");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_w_m1)
        else $error("column counter beyond frame width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_hp1)
        else $error("row counter beyond frame end");

endmodule

@@ dv/sobel_edge_filter_3x3_core_tb.sv @@
// Self-checking stream testbench for the 3x3 Sobel edge filter core.
module sobel_edge_filter_3x3_core_tb;
    import sfe_pkg::*;

    localparam int MAX_W      = 512;
    localparam int MAX_H      = 512;
    localparam int RAND_BEATS = 1600;
    localparam int SETTLE_CYC = 16;
    localparam int HOLD_CYC   = 300;

    // Directed frames at 3x3: bright top row, a drain inside the frame,
    // pixel beats past the frame end, then a frame with negative sums.
    localparam logic [25:0] DIR_DRAIN = 26'b11_1100_0000_0001_0100_0001_0000;
    localparam t_pix DIR_PX [26] = '{
        8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
        8'd170, 8'd0,   8'd85,  8'd0,
        8'd0,   8'd0,   8'd0,   8'd255, 8'd128, 8'd0,   8'd255, 8'd255, 8'd255,
        8'd0,   8'd0,   8'd0,   8'd0
    };

    // Edge response predictor and store of expected result beats
    class edge_response_model;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        t_pix    older_row [MAX_W];
        t_pix    newer_row [MAX_W];
        t_col    win_left;
        t_col    win_centre;
        int      col_pos;
        int      row_pos;
        int      emitted;
        t_result pending_edges [$];
        int      mismatches;

        function new();
            width_reg  = CFG_W'(CFG_RST);
            height_reg = CFG_W'(CFG_RST);
            foreach (older_row[i]) begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            col_pos    = 0;
            row_pos    = 0;
            emitted    = 0;
            win_left   = '0;
            win_centre = '0;
        endfunction

        function int clip_dim(int v, int hi);
            if (v < MIN_DIM) return MIN_DIM;
            if (v > hi) return hi;
            return v;
        endfunction

        function int eff_width();
            return clip_dim(int'(width_reg), MAX_W);
        endfunction

        function int eff_height();
            return clip_dim(int'(height_reg), MAX_H);
        endfunction

        function t_pix clamp_byte(int s);
            if (s < 0) return 8'd0;
            if (s > 255) return 8'd255;
            return t_pix'(s);
        endfunction

        // Any register write restarts the frame; line stores are kept
        function void write_reg(logic idx, logic [31:0] val);
            if (idx == REG_WIDTH) width_reg = val[CFG_W-1:0];
            else height_reg = val[CFG_W-1:0];
            restart();
        endfunction

        // One accepted input beat: shift line stores and window, predict result
        function void take_beat(logic act, t_pix px);
            int      w;
            int      h;
            int      hs;
            int      vs;
            t_pix    cur;
            t_pix    top;
            t_pix    mid;
            t_col    right;
            logic    fire;
            t_result res;
            w   = eff_width();
            h   = eff_height();
            cur = (row_pos < h && act == ACT_PIXEL) ? px : 8'd0;
            top = (row_pos >= 2) ? older_row[col_pos] : 8'd0;
            mid = (row_pos >= 1) ? newer_row[col_pos] : 8'd0;
            older_row[col_pos] = newer_row[col_pos];
            newer_row[col_pos] = cur;

            // column 0 closes the previous row with a zero right column
            if (col_pos == 0) begin
                fire  = (row_pos >= 2);
                right = '0;
            end else begin
                fire      = (row_pos >= 1);
                right.top = top;
                right.mid = mid;
                right.bot = cur;
            end
            res = '0;
            if (fire) begin
                hs = (int'(win_left.top) + 2 * int'(win_centre.top) + int'(right.top))
                   - (int'(win_left.bot) + 2 * int'(win_centre.bot) + int'(right.bot));
                vs = (int'(win_left.top) + 2 * int'(win_left.mid) + int'(win_left.bot))
                   - (int'(right.top) + 2 * int'(right.mid) + int'(right.bot));
                res.horiz = clamp_byte(hs);
                res.vert  = clamp_byte(vs);
            end

            if (col_pos == 0) win_left = '0;
            else win_left = win_centre;
            win_centre.top = top;
            win_centre.mid = mid;
            win_centre.bot = cur;

            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end

            if (fire) begin
                emitted++;
                res.last = (emitted >= w * h);
                pending_edges.push_back(res);
                if (res.last) restart();
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        // One accepted output beat against the oldest expected beat
        task check_beat(t_result got);
            t_result want;
            if (pending_edges.size() == 0) begin
                report_mismatch($sformatf("unexpected beat h=%0d v=%0d last=%0b",
                                          got.horiz, got.vert, got.last));
                return;
            end
            want = pending_edges.pop_front();
            if (got.horiz !== want.horiz)
                report_mismatch($sformatf("horizontal_edge %0d, want %0d",
                                          got.horiz, want.horiz));
            if (got.vert !== want.vert)
                report_mismatch($sformatf("vertical_edge %0d, want %0d",
                                          got.vert, want.vert));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    edge_response_model edge_model;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit long_hold_req = 1'b0;
    int random_sent   = 0;

    sobel_edge_filter_3x3_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #400000;
        $display("[sobel_edge_filter_3x3_core] ERROR");
        $finish;
    end

    // Output ready: random stalls, plus one long hold on request
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_seen) begin
                hold_left = HOLD_CYC;
                hold_seen = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Output monitor
    initial begin
        t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid === 1'b1 && m_tready) begin
                got = {m_tlast, m_tdata[15:8], m_tdata[7:0]};
                edge_model.check_beat(got);
            end
        end
    end

    function automatic logic rand_action(int drain_pct);
        return ($urandom_range(99) < drain_pct) ? ACT_DRAIN : ACT_PIXEL;
    endfunction

    // Bias toward black and white to hit both clamp limits
    function automatic t_pix rand_pixel();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return t_pix'($urandom_range(255));
        endcase
    endfunction

    // Offer one input beat; called and returns at a falling edge
    task automatic send_beat(input logic act, input t_pix px);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = t_pix'($urandom);
            s_tuser  = 1'($urandom);
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        s_tuser  = act;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        edge_model.take_beat(act, px);
        @(negedge i_clk);
    endtask

    // APB write: setup then access phase
    task automatic write_reg(input logic idx, input int unsigned val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        edge_model.write_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Wait for every expected beat, then let the pipeline go quiet
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (edge_model.pending_edges.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Whole frames plus a flush tail; the last frame may be cut short
    task automatic send_frames(input int n_frames);
        int w;
        int h;
        int total;
        bit cut;
        w = edge_model.eff_width();
        h = edge_model.eff_height();
        for (int f = 0; f < n_frames; f++) begin
            total = w * h + w + 1;
            cut   = ($urandom_range(99) < 15);
            if (cut) total = $urandom_range(1, total - 1);
            for (int k = 0; k < total; k++) begin
                if (k < w * h) send_beat(rand_action(6), rand_pixel());
                else send_beat(rand_action(80), rand_pixel());
            end
            random_sent += total;
            if (cut) break;
        end
    endtask

    // Open-ended run for the large frame sizes
    task automatic send_run(input int n);
        for (int k = 0; k < n; k++) send_beat(rand_action(3), rand_pixel());
        random_sent += n;
    endtask

    initial begin
        int phase;
        int wv;
        int hv;
        int pick;
        bit hold_done;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_PIXEL;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        edge_model = new();
        hold_done  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames at the minimum size
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        for (int k = 0; k < 26; k++)
            send_beat(DIR_DRAIN[k] ? ACT_DRAIN : ACT_PIXEL, DIR_PX[k]);
        wait_drained();

        // Random phases, each under a fresh frame setting
        phase = 0;
        while (random_sent < RAND_BEATS) begin
            if (random_sent < RAND_BEATS / 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 59;
            end else if (random_sent < 2 * RAND_BEATS / 3) begin
                send_idle_pct = 59;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!hold_done) begin
                    long_hold_req = 1'b1;
                    hold_done     = 1'b1;
                end
            end
            case (phase)
                2: begin
                    // widest line, written out of range so it saturates
                    write_reg(REG_WIDTH, 1023);
                    write_reg(REG_HEIGHT, $urandom_range(3, 6));
                    send_run(540);
                end
                5: begin
                    // tallest frame on the narrowest line
                    write_reg(REG_WIDTH, 2);
                    write_reg(REG_HEIGHT, 512);
                    send_run(220);
                end
                default: begin
                    pick = $urandom_range(99);
                    wv = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
                    hv = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                    if (pick < 85) write_reg(REG_WIDTH, wv);
                    if (pick >= 15) write_reg(REG_HEIGHT, hv);
                    send_frames($urandom_range(1, 3));
                end
            endcase
            wait_drained();
            phase++;
        end

        wait_drained();
        if (edge_model.mismatches == 0) begin
            $display("[sobel_edge_filter_3x3_core] OK");
        end else begin
            $display("[sobel_edge_filter_3x3_core] ERROR");
        end
        $finish;
    end

endmodule
